[sv/lru_pr_pkg.sv]
// Shared types, widths and defaults for the LRU page replacement block.
// Used by lru_pr_cell and lru_page_replacement; no dependencies.
package lru_pr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_W  = 16;   // page field width on the stream
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

  // Control bits of the lookup probe that walks the cell chain
  typedef struct packed {
    logic valid;
    logic found;   // a matching active frame has been seen
    logic min_ok;  // min_idx / min_rank hold a candidate victim
  } probe_ctl_t;

  // Rank/fill update broadcast to every cell
  typedef struct packed {
    logic en;
    logic fill;    // fault: load the new page into the slot
  } upd_t;

  function automatic int idx_w(input int frames);
    return (frames > 1) ? $clog2(frames) : 1;
  endfunction

  function automatic int act_w(input int frames);
    return ($clog2(frames + 1) > CFG_W) ? $clog2(frames + 1) : CFG_W;
  endfunction

  function automatic int page_w(input int bits);
    return (bits < PAGE_W) ? bits : PAGE_W;
  endfunction

endpackage

[sv/lru_pr_cell.sv]
// One frame of the LRU chain: resident page, valid bit and recency rank.
// Passes the lookup probe on to its neighbor; depends on lru_pr_pkg.
module lru_pr_cell #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
  parameter int IDX       = 0,
  localparam int IW = lru_pr_pkg::idx_w(FRAMES),
  localparam int AW = lru_pr_pkg::act_w(FRAMES),
  localparam int PW = lru_pr_pkg::page_w(PAGE_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic [AW-1:0]           active,
  input  lru_pr_pkg::probe_ctl_t  in_ctl,
  input  logic [PW-1:0]           in_page,
  input  logic [IW-1:0]           in_hit_idx,
  input  logic [IW-1:0]           in_hit_rank,
  input  logic [IW-1:0]           in_min_idx,
  input  logic [IW-1:0]           in_min_rank,
  output lru_pr_pkg::probe_ctl_t  out_ctl,
  output logic [PW-1:0]           out_page,
  output logic [IW-1:0]           out_hit_idx,
  output logic [IW-1:0]           out_hit_rank,
  output logic [IW-1:0]           out_min_idx,
  output logic [IW-1:0]           out_min_rank,
  input  lru_pr_pkg::upd_t        upd,
  input  logic [IW-1:0]           upd_slot,
  input  logic [IW-1:0]           upd_old_rank,
  input  logic [PW-1:0]           upd_page
);
  import lru_pr_pkg::*;

  logic [PW-1:0] page;
  logic          fvalid;
  logic [IW-1:0] rank;

  logic act, match, better;

  assign act    = AW'(IDX) < active;
  assign match  = act && fvalid && (page == in_page);
  assign better = act && (!in_ctl.min_ok || (rank < in_min_rank));

  // frame state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fvalid <= 1'b0;
      rank   <= IW'(IDX);
    end else if (upd.en) begin
      if (upd_slot == IW'(IDX)) begin
        rank <= IW'(FRAMES - 1);
        if (upd.fill) begin
          fvalid <= 1'b1;
        end
      end else if (rank > upd_old_rank) begin
        rank <= rank - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.fill && (upd_slot == IW'(IDX))) begin
      page <= upd_page;
    end
  end

  // probe stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid  <= in_ctl.valid;
      out_ctl.found  <= in_ctl.found | match;
      out_ctl.min_ok <= in_ctl.min_ok | better;
    end
  end

  always_ff @(posedge clk) begin
    out_page <= in_page;
    if (!in_ctl.found && match) begin
      out_hit_idx  <= IW'(IDX);
      out_hit_rank <= rank;
    end else begin
      out_hit_idx  <= in_hit_idx;
      out_hit_rank <= in_hit_rank;
    end
    if (better) begin
      out_min_idx  <= IW'(IDX);
      out_min_rank <= rank;
    end else begin
      out_min_idx  <= in_min_idx;
      out_min_rank <= in_min_rank;
    end
  end

endmodule

[sv/lru_page_replacement.sv]
// Top level of the LRU page replacement block: stream ports, control and
// the chain of lru_pr_cell frames; depends on lru_pr_pkg and lru_pr_cell.
//
//  channel   signals                    content (low bit first)
//  -------   -------------------------  ------------------------------------
//  s_axis    tvalid tready tdata tuser  tdata: page[15:0]; tuser: first_of_run
//  m_axis    tvalid tready tdata        tdata: hit, slot[3:0], hit_total[31:0],
//                                       fault_total[31:0], 3 zero bits
//  cfg       cfg_wr_en cfg_wr_data      frames_in_use[4:0]
//
// A reference passes the accept edge, a register in every cell as the probe
// walks the chain, the capture of the probe result and the rank/fill update;
// tready is high again right after the update.
// A new reference is taken once the update is done, even while the result
// waits in the output register; the update waits until that register frees.
// Reset empties all frames, sets rank = frame index and zeroes the totals.
module lru_page_replacement #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lru_pr_pkg::PAGE_W-1:0]       s_axis_tdata,  // page
  input  logic                                s_axis_tuser,  // first_of_run
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [71:0]                         m_axis_tdata,  // hit, slot, hit_total,
                                                             // fault_total, pad
  input  logic                                cfg_wr_en,
  input  logic [lru_pr_pkg::CFG_W-1:0]        cfg_wr_data    // frames_in_use
);
  import lru_pr_pkg::*;

  localparam int IW = idx_w(FRAMES);
  localparam int AW = act_w(FRAMES);
  localparam int PW = page_w(PAGE_BITS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state, state_next;

  logic [CFG_W-1:0] frames_in_use;
  logic [AW-1:0]    active, active_next;

  // chain taps: index 0 is the launch, index i+1 is cell i's output
  probe_ctl_t    ch_ctl      [FRAMES+1];
  logic [PW-1:0] ch_page     [FRAMES+1];
  logic [IW-1:0] ch_hit_idx  [FRAMES+1];
  logic [IW-1:0] ch_hit_rank [FRAMES+1];
  logic [IW-1:0] ch_min_idx  [FRAMES+1];
  logic [IW-1:0] ch_min_rank [FRAMES+1];

  logic          launch_valid;
  logic [PW-1:0] launch_page;

  logic          res_found;
  logic [IW-1:0] res_slot;
  logic [IW-1:0] res_old_rank;
  logic [PW-1:0] res_page;

  logic [TOTAL_W-1:0] hits, faults, hits_next, faults_next;

  logic               out_valid;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic [TOTAL_W-1:0] out_hits, out_faults;

  logic accept, clear, out_free, do_update, tail_valid;
  upd_t upd;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clear         = accept && s_axis_tuser;
  assign out_free      = !out_valid || m_axis_tready;
  assign do_update     = (state == S_UPDATE) && out_free;
  assign tail_valid    = ch_ctl[FRAMES].valid;

  assign upd.en   = do_update;
  assign upd.fill = !res_found;

  // frames_in_use of zero acts as one, above FRAMES as FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      active_next = AW'(1);
    end else if (AW'(frames_in_use) > AW'(FRAMES)) begin
      active_next = AW'(FRAMES);
    end else begin
      active_next = AW'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept)     state_next = S_SEARCH;
      S_SEARCH: if (tail_valid) state_next = S_UPDATE;
      S_UPDATE: if (out_free)   state_next = S_IDLE;
      default:                  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch_valid <= 1'b0;
    end else begin
      state        <= state_next;
      launch_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch_page <= s_axis_tdata[PW-1:0];
      active      <= active_next;
    end
  end

  assign ch_ctl[0]      = '{valid: launch_valid, found: 1'b0, min_ok: 1'b0};
  assign ch_page[0]     = launch_page;
  assign ch_hit_idx[0]  = '0;
  assign ch_hit_rank[0] = '0;
  assign ch_min_idx[0]  = '0;
  assign ch_min_rank[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lru_pr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .clear        (clear),
      .active       (active),
      .in_ctl       (ch_ctl[i]),
      .in_page      (ch_page[i]),
      .in_hit_idx   (ch_hit_idx[i]),
      .in_hit_rank  (ch_hit_rank[i]),
      .in_min_idx   (ch_min_idx[i]),
      .in_min_rank  (ch_min_rank[i]),
      .out_ctl      (ch_ctl[i+1]),
      .out_page     (ch_page[i+1]),
      .out_hit_idx  (ch_hit_idx[i+1]),
      .out_hit_rank (ch_hit_rank[i+1]),
      .out_min_idx  (ch_min_idx[i+1]),
      .out_min_rank (ch_min_rank[i+1]),
      .upd          (upd),
      .upd_slot     (res_slot),
      .upd_old_rank (res_old_rank),
      .upd_page     (res_page)
    );
  end

  // hold the probe result until the output register can take it
  always_ff @(posedge clk) begin
    if (state == S_SEARCH && tail_valid) begin
      res_found    <= ch_ctl[FRAMES].found;
      res_slot     <= ch_ctl[FRAMES].found ? ch_hit_idx[FRAMES]  : ch_min_idx[FRAMES];
      res_old_rank <= ch_ctl[FRAMES].found ? ch_hit_rank[FRAMES] : ch_min_rank[FRAMES];
      res_page     <= ch_page[FRAMES];
    end
  end

  // saturating totals
  always_comb begin
    hits_next   = hits;
    faults_next = faults;
    if (res_found) begin
      if (hits != '1) hits_next = hits + 1'b1;
    end else begin
      if (faults != '1) faults_next = faults + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hits   <= '0;
      faults <= '0;
    end else if (do_update) begin
      hits   <= hits_next;
      faults <= faults_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_update) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_hit    <= res_found;
      out_slot   <= SLOT_W'(res_slot);
      out_hits   <= hits_next;
      out_faults <= faults_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_faults, out_hits, out_slot, out_hit};

endmodule

[bench/lru_page_replacement_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for lru_page_replacement: directed and random page references,
// checked against an in-bench LRU frame predictor. Depends on lru_pr_pkg and the block.
module lru_page_replacement_test;
  import lru_pr_pkg::*;

  localparam int NFRAMES   = 16;
  localparam int IDLE_TAIL = 30;

  typedef struct {
    bit                 hit;
    bit [SLOT_W-1:0]    slot;
    bit [TOTAL_W-1:0]   hits;
    bit [TOTAL_W-1:0]   faults;
  } access_outcome_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [PAGE_W-1:0]  s_axis_tdata;   // page
  logic               s_axis_tuser;   // first_of_run
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [71:0]        m_axis_tdata;   // hit, slot[3:0], hit_total, fault_total, pad
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;    // frames_in_use

  // predictor state
  bit [PAGE_W-1:0]    frame_page [NFRAMES];
  bit                 frame_used [NFRAMES];
  bit [3:0]           frame_rank [NFRAMES];
  bit [TOTAL_W-1:0]   hit_count;
  bit [TOTAL_W-1:0]   fault_count;
  bit [CFG_W-1:0]     active_frames_reg;

  access_outcome_t    pending_outcomes[$];
  int                 errors;
  int                 refs_sent;
  int                 outcomes_checked;
  bit                 gaps_on;

  lru_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_frames();
    for (int i = 0; i < NFRAMES; i++) begin
      frame_page[i] = '0;
      frame_used[i] = 1'b0;
      frame_rank[i] = i[3:0];
    end
    hit_count   = '0;
    fault_count = '0;
  endtask

  task automatic predict_access(input bit [PAGE_W-1:0] pg, input bit restart,
                                output access_outcome_t res);
    int       active;
    int       victim;
    bit [3:0] old_rank;
    res = '{default: '0};
    if (restart) clear_frames();
    active = int'(active_frames_reg);
    if (active < 1) active = 1;
    if (active > NFRAMES) active = NFRAMES;
    victim = -1;
    for (int i = 0; i < active; i++) begin
      if (victim < 0 && frame_used[i] && frame_page[i] == pg) victim = i;
    end
    if (victim >= 0) begin
      res.hit = 1'b1;
      if (hit_count != '1) hit_count++;
    end else begin
      victim = 0;
      for (int i = 1; i < active; i++) begin
        if (frame_rank[i] < frame_rank[victim]) victim = i;
      end
      frame_page[victim] = pg;
      frame_used[victim] = 1'b1;
      if (fault_count != '1) fault_count++;
    end
    // touched frame becomes most recent; ranks above it slide down
    old_rank = frame_rank[victim];
    for (int i = 0; i < NFRAMES; i++) begin
      if (frame_rank[i] > old_rank) frame_rank[i]--;
    end
    frame_rank[victim] = 4'(NFRAMES - 1);
    res.slot   = victim[SLOT_W-1:0];
    res.hits   = hit_count;
    res.faults = fault_count;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    access_outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none expected, tdata=%h", m_axis_tdata));
      end else begin
        want = pending_outcomes.pop_front();
        outcomes_checked++;
        if (m_axis_tdata[0] !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", m_axis_tdata[0], want.hit));
        if (m_axis_tdata[4:1] !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", m_axis_tdata[4:1], want.slot));
        if (m_axis_tdata[36:5] !== want.hits)
          report_mismatch($sformatf("hit_total %0d, want %0d", m_axis_tdata[36:5],
                                    want.hits));
        if (m_axis_tdata[68:37] !== want.faults)
          report_mismatch($sformatf("fault_total %0d, want %0d", m_axis_tdata[68:37],
                                    want.faults));
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_axis_tready <= !gaps_on || ($urandom_range(99) >= 34);
  end

  task automatic send_ref(input bit [PAGE_W-1:0] pg, input bit restart);
    access_outcome_t res;
    if (gaps_on && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_access(pg, restart, res);
    pending_outcomes.push_back(res);
    refs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic set_frames(input bit [CFG_W-1:0] value);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    active_frames_reg = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // reset default of three frames, page extremes, hit and eviction
  task automatic test_default_frames();
    send_ref(16'h0000, 1'b1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hABCD, 1'b0);   // evicts 16'hFFFF
    send_ref(16'hFFFF, 1'b0);
  endtask

  // zero acts as one frame, oversize values clamp to all frames
  task automatic test_active_limits();
    set_frames(5'd0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0006, 1'b0);
    set_frames(5'd31);
    send_ref(16'h0007, 1'b0);
    send_ref(16'hFFFF, 1'b0);   // kept in an inactive frame earlier
    set_frames(5'd17);
    send_ref(16'h8000, 1'b0);
  endtask

  // same page in two frames after a shrink; lowest index wins
  task automatic test_duplicate_page();
    set_frames(5'd2);
    send_ref(16'h0F0F, 1'b1);
    send_ref(16'h5A5A, 1'b0);
    set_frames(5'd1);
    send_ref(16'h3C3C, 1'b0);
    send_ref(16'h5A5A, 1'b0);   // frame 1 inactive, so this faults into frame 0
    set_frames(5'd2);
    send_ref(16'h5A5A, 1'b0);
  endtask

  // first_of_run drops resident pages and clears totals
  task automatic test_run_restart();
    send_ref(16'h5A5A, 1'b1);
    send_ref(16'h5A5A, 1'b0);
    send_ref(16'h5A5A, 1'b1);
  endtask

  task automatic test_random_traffic();
    int              phase_frames[11] = '{1, 2, 4, 7, 16, 8, 31, 0, 15, 17, 3};
    bit [PAGE_W-1:0] pool[$];
    int              eff;
    int              pick;
    bit [PAGE_W-1:0] pg;
    for (int p = 0; p < 11; p++) begin
      set_frames(phase_frames[p][CFG_W-1:0]);
      gaps_on = (p != 4);       // one phase runs at full rate on both sides
      eff = phase_frames[p];
      if (eff < 1) eff = 1;
      if (eff > NFRAMES) eff = NFRAMES;
      pool.delete();
      repeat ($urandom_range(1, eff + 3)) pool.push_back(PAGE_W'($urandom_range(0, 65535)));
      for (int n = 0; n < 36; n++) begin
        pick = $urandom_range(99);
        if (pick < 88) pg = pool[$urandom_range(0, pool.size() - 1)];
        else pg = PAGE_W'($urandom_range(0, 65535));
        send_ref(pg, $urandom_range(99) < 3);
      end
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    gaps_on       = 1'b1;
    errors        = 0;
    refs_sent     = 0;
    outcomes_checked = 0;
    active_frames_reg = CFG_RESET;
    clear_frames();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_frames();
    test_active_limits();
    test_duplicate_page();
    test_run_restart();
    test_random_traffic();
    wait_until_idle();

    $display("Covered %0d page references over frame counts 0..31 with restarts;",
             refs_sent);
    $display("%0d results compared, %0d mismatches.", outcomes_checked, errors);
    if (errors == 0) begin
      $display("** lru_page_replacement: PASSED **");
    end else begin
      $display("** lru_page_replacement: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout: %0d results still outstanding", pending_outcomes.size());
    $display("** lru_page_replacement: FAILED **");
    $finish;
  end

endmodule
